FILE: hw/rtl/marching_squares_cell_macros.svh
// Assertion macros used by the checker in msq_checker.sv.
`ifndef MARCHING_SQUARES_CELL_MACROS_SVH
`define MARCHING_SQUARES_CELL_MACROS_SVH

// Check while out of reset.
`define MSQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("marching squares assertion failed");

// Check at every edge, reset included.
`define MSQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("marching squares reset assertion failed");

`endif

FILE: hw/rtl/msq_pkg.sv
`default_nettype none
package msq_pkg;

  localparam int GRID_POINTS = 1024;
  localparam logic [9:0] COL_MAX = 10'(GRID_POINTS - 2);

  localparam logic [2:0] CFG_ISO_LEVEL = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_A  = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_B  = 3'd2;
  localparam logic [2:0] CFG_STEP_A    = 3'd3;
  localparam logic [2:0] CFG_STEP_B    = 3'd4;

  localparam logic [30:0] STEP_RESET = 31'd65536;

  typedef enum logic [1:0] {
    EDGE_LEFT,
    EDGE_RIGHT,
    EDGE_BOTTOM,
    EDGE_TOP
  } msq_edge_t;

  typedef struct packed {
    logic [9:0]         cell_col;
    logic [9:0]         cell_row;
    logic signed [31:0] corner_lb;
    logic signed [31:0] corner_rb;
    logic signed [31:0] corner_lt;
    logic signed [31:0] corner_rt;
  } msq_in_t;

  typedef struct packed {
    logic signed [31:0] vertex_a;
    logic signed [31:0] vertex_b;
    logic               last_vertex;
  } msq_out_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] value;
  } msq_cfg_t;

  function automatic logic [2:0] case_count(input logic [3:0] cs);
    logic [2:0] n;
    unique case (cs)
      4'd0, 4'd15: n = 3'd0;
      4'd6, 4'd9:  n = 3'd4;
      default:     n = 3'd2;
    endcase
    return n;
  endfunction

  function automatic msq_edge_t case_edge(input logic [3:0] cs, input logic [1:0] k);
    msq_edge_t e0, e1, e2, e3;
    e0 = EDGE_LEFT;
    e1 = EDGE_LEFT;
    e2 = EDGE_LEFT;
    e3 = EDGE_LEFT;
    unique case (cs)
      4'd1, 4'd14: begin e0 = EDGE_LEFT;  e1 = EDGE_BOTTOM; end
      4'd2, 4'd13: begin e0 = EDGE_RIGHT; e1 = EDGE_BOTTOM; end
      4'd3, 4'd12: begin e0 = EDGE_LEFT;  e1 = EDGE_RIGHT;  end
      4'd4:        begin e0 = EDGE_LEFT;  e1 = EDGE_TOP;    end
      4'd5, 4'd10: begin e0 = EDGE_TOP;   e1 = EDGE_BOTTOM; end
      4'd6: begin
        e0 = EDGE_LEFT; e1 = EDGE_TOP; e2 = EDGE_RIGHT; e3 = EDGE_BOTTOM;
      end
      4'd7, 4'd8:  begin e0 = EDGE_TOP;   e1 = EDGE_RIGHT;  end
      4'd9: begin
        e0 = EDGE_TOP; e1 = EDGE_RIGHT; e2 = EDGE_BOTTOM; e3 = EDGE_LEFT;
      end
      4'd11:       begin e0 = EDGE_TOP;   e1 = EDGE_LEFT;   end
      default: ;
    endcase
    unique case (k)
      2'd0: return e0;
      2'd1: return e1;
      2'd2: return e2;
      default: return e3;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [43:0] x);
    if (x > 44'sd2147483647) return 32'sh7fffffff;
    if (x < -44'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/msq_stream_if.sv
`default_nettype none
interface msq_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/marching_squares_cell.sv
// Path from cell transaction to out_if: cell, edge select, difference, multiply, divider and output registers.
// Throughput: one vertex per cycle while out_if is ready; a cell holds the input
// until its last vertex enters edge select, and a cell with no vertices still occupies the cell stage.
// Divider: 16 stages of 2 restoring quotient bits each, after one multiply stage.
// Reset: synchronous active-low rst_n clears valid bits and loads register defaults.
`default_nettype none
module marching_squares_cell (
  input  wire                 clk,
  input  wire                 rst_n,
  msq_stream_if.sink          in_if,
  msq_stream_if.source        out_if,
  msq_stream_if.sink          cfg_if
);

  localparam int DIV_STAGES = 16;

  logic signed [31:0] iso_r, org_a_r, org_b_r;
  logic [30:0]        step_a_r, step_b_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iso_r    <= '0;
      org_a_r  <= '0;
      org_b_r  <= '0;
      step_a_r <= msq_pkg::STEP_RESET;
      step_b_r <= msq_pkg::STEP_RESET;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.data.index)
        msq_pkg::CFG_ISO_LEVEL: iso_r    <= cfg_if.data.value;
        msq_pkg::CFG_ORIGIN_A:  org_a_r  <= cfg_if.data.value;
        msq_pkg::CFG_ORIGIN_B:  org_b_r  <= cfg_if.data.value;
        msq_pkg::CFG_STEP_A:    step_a_r <= cfg_if.data.value[30:0];
        msq_pkg::CFG_STEP_B:    step_b_r <= cfg_if.data.value[30:0];
        default: ;
      endcase
    end
  end

  logic adv, out_v_r;
  msq_pkg::msq_out_t out_r;
  assign adv = !out_v_r || out_if.ready;

  // cell stage
  msq_pkg::msq_in_t cell_r;
  logic cell_v_r;
  logic [1:0] k_r;
  logic [3:0] cs;
  logic [2:0] n;
  logic job_v, job_last, cell_done, in_acc;
  msq_pkg::msq_edge_t job_edge;

  assign cs = {cell_r.corner_rt > iso_r, cell_r.corner_lt > iso_r,
               cell_r.corner_rb > iso_r, cell_r.corner_lb > iso_r};
  assign n         = msq_pkg::case_count(cs);
  assign job_v     = cell_v_r && (n != 3'd0);
  assign job_last  = ({1'b0, k_r} + 3'd1) == n;
  assign job_edge  = msq_pkg::case_edge(cs, k_r);
  assign cell_done = cell_v_r && adv && ((n == 3'd0) || job_last);
  assign in_if.ready = !cell_v_r || cell_done;
  assign in_acc    = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_v_r <= 1'b0;
      k_r      <= '0;
    end else if (in_acc) begin
      cell_v_r <= 1'b1;
      k_r      <= '0;
    end else if (cell_done) begin
      cell_v_r <= 1'b0;
    end else if (adv && job_v) begin
      k_r <= k_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) cell_r <= in_if.data;
  end

  // edge select
  logic s1_v_r, s1_last_r;
  msq_pkg::msq_edge_t s1_edge_r;
  logic signed [31:0] s1_v0_r, s1_v1_r;
  logic [9:0] s1_col_r, s1_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (adv) s1_v_r <= job_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_edge_r <= job_edge;
      s1_last_r <= job_last;
      s1_col_r  <= (cell_r.cell_col > msq_pkg::COL_MAX) ? msq_pkg::COL_MAX : cell_r.cell_col;
      s1_row_r  <= (cell_r.cell_row > msq_pkg::COL_MAX) ? msq_pkg::COL_MAX : cell_r.cell_row;
      unique case (job_edge)
        msq_pkg::EDGE_LEFT:   begin s1_v0_r <= cell_r.corner_lb; s1_v1_r <= cell_r.corner_lt; end
        msq_pkg::EDGE_RIGHT:  begin s1_v0_r <= cell_r.corner_rb; s1_v1_r <= cell_r.corner_rt; end
        msq_pkg::EDGE_BOTTOM: begin s1_v0_r <= cell_r.corner_lb; s1_v1_r <= cell_r.corner_rb; end
        default:              begin s1_v0_r <= cell_r.corner_lt; s1_v1_r <= cell_r.corner_rt; end
      endcase
    end
  end

  // differences and base products
  logic signed [32:0] num, den;
  logic s2_v_r, s2_last_r;
  msq_pkg::msq_edge_t s2_edge_r;
  logic [31:0] s2_nmag_r, s2_dmag_r;
  logic [30:0] s2_s_r;
  logic [40:0] s2_pa_r, s2_pb_r;

  assign num = {iso_r[31], iso_r} - {s1_v0_r[31], s1_v0_r};
  assign den = {s1_v1_r[31], s1_v1_r} - {s1_v0_r[31], s1_v0_r};

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (adv) s2_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_edge_r <= s1_edge_r;
      s2_last_r <= s1_last_r;
      s2_nmag_r <= num[32] ? 32'(-num) : num[31:0];
      s2_dmag_r <= den[32] ? 32'(-den) : den[31:0];
      s2_s_r    <= (s1_edge_r == msq_pkg::EDGE_LEFT || s1_edge_r == msq_pkg::EDGE_RIGHT)
                   ? step_b_r : step_a_r;
      s2_pa_r   <= 41'(s1_col_r) * 41'(step_a_r);
      s2_pb_r   <= 41'(s1_row_r) * 41'(step_b_r);
    end
  end

  // divider pipe: index 0 is the multiply stage
  logic               dv_v_r    [0:DIV_STAGES];
  logic               dv_last_r [0:DIV_STAGES];
  logic               dv_onto_r [0:DIV_STAGES];
  logic signed [43:0] dv_a_r    [0:DIV_STAGES];
  logic signed [43:0] dv_b_r    [0:DIV_STAGES];
  logic [31:0]        dv_rem_r  [0:DIV_STAGES];
  logic [31:0]        dv_low_r  [0:DIV_STAGES];
  logic [31:0]        dv_q_r    [0:DIV_STAGES];
  logic [31:0]        dv_d_r    [0:DIV_STAGES];
  logic [62:0]        prod;

  assign prod = 63'(s2_nmag_r) * 63'(s2_s_r);

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else if (adv) dv_v_r[0] <= s2_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_last_r[0] <= s2_last_r;
      dv_onto_r[0] <= (s2_edge_r == msq_pkg::EDGE_BOTTOM || s2_edge_r == msq_pkg::EDGE_TOP);
      dv_a_r[0]    <= 44'(org_a_r) + 44'(s2_pa_r)
                      + ((s2_edge_r == msq_pkg::EDGE_RIGHT) ? 44'(step_a_r) : 44'sd0);
      dv_b_r[0]    <= 44'(org_b_r) + 44'(s2_pb_r)
                      + ((s2_edge_r == msq_pkg::EDGE_TOP) ? 44'(step_b_r) : 44'sd0);
      dv_rem_r[0]  <= {1'b0, prod[62:32]};
      dv_low_r[0]  <= prod[31:0];
      dv_q_r[0]    <= '0;
      dv_d_r[0]    <= s2_dmag_r;
    end
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic [31:0] rem_nxt, low_nxt, q_nxt;

    always_comb begin
      logic [32:0] t;
      rem_nxt = dv_rem_r[j];
      low_nxt = dv_low_r[j];
      q_nxt   = dv_q_r[j];
      for (int i = 0; i < 2; i++) begin
        t = {rem_nxt, low_nxt[31]};
        low_nxt = {low_nxt[30:0], 1'b0};
        if (t >= {1'b0, dv_d_r[j]}) begin
          t = t - {1'b0, dv_d_r[j]};
          q_nxt = {q_nxt[30:0], 1'b1};
        end else begin
          q_nxt = {q_nxt[30:0], 1'b0};
        end
        rem_nxt = t[31:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[j+1] <= 1'b0;
      else if (adv) dv_v_r[j+1] <= dv_v_r[j];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_last_r[j+1] <= dv_last_r[j];
        dv_onto_r[j+1] <= dv_onto_r[j];
        dv_a_r[j+1]    <= dv_a_r[j];
        dv_b_r[j+1]    <= dv_b_r[j];
        dv_d_r[j+1]    <= dv_d_r[j];
        dv_rem_r[j+1]  <= rem_nxt;
        dv_low_r[j+1]  <= low_nxt;
        dv_q_r[j+1]    <= q_nxt;
      end
    end
  end

  // output register
  logic [43:0] q_ext;
  assign q_ext = 44'(dv_q_r[DIV_STAGES]);

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (adv) out_v_r <= dv_v_r[DIV_STAGES];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.vertex_a    <= msq_pkg::sat32(dv_a_r[DIV_STAGES]
                           + (dv_onto_r[DIV_STAGES] ? $signed(q_ext) : 44'sd0));
      out_r.vertex_b    <= msq_pkg::sat32(dv_b_r[DIV_STAGES]
                           + (dv_onto_r[DIV_STAGES] ? 44'sd0 : $signed(q_ext)));
      out_r.last_vertex <= dv_last_r[DIV_STAGES];
    end
  end

  assign out_if.valid = out_v_r;
  assign out_if.data  = out_r;

endmodule
`default_nettype wire

FILE: hw/rtl/msq_checker.sv
`default_nettype none
`include "marching_squares_cell_macros.svh"
module msq_checker (
  input wire                    clk,
  input wire                    rst_n,
  input wire                    in_valid,
  input wire                    in_ready,
  input wire                    out_valid,
  input wire                    out_ready,
  input wire msq_pkg::msq_out_t out_data,
  input wire                    cfg_valid,
  input wire                    cfg_ready
);

  `MSQ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))
  `MSQ_ASSERT_ALWAYS(a_out_reset, !rst_n |=> !out_valid)
  `MSQ_ASSERT_ALWAYS(a_in_ready_reset, !rst_n |=> in_ready)
  `MSQ_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready)

endmodule

bind marching_squares_cell msq_checker u_msq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data),
  .cfg_valid (cfg_if.valid),
  .cfg_ready (cfg_if.ready)
);
`default_nettype wire
